>>> hdl/bgzf_block_scanner_macros.svh
// ============================================================================
// Assertion macros for the block scanner
// Concurrent assertion forms clocked on clk and disabled during reset.
// ============================================================================
`ifndef BGZF_BLOCK_SCANNER_MACROS_SVH
`define BGZF_BLOCK_SCANNER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BGZF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BGZF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/bgzf_pkg.sv
// ============================================================================
// Block scanner package
// Shared constants, result types and header tables for the block scanner.
// ============================================================================
`default_nettype none

package bgzf_pkg;

	localparam int OFFSET_BITS     = 48;
	localparam int OUT_OFS_BITS    = 48;
	localparam int LEN_BITS        = 17;
	localparam int HDR_BYTES       = 18;
	localparam int FOOTER_BYTES    = 8;
	localparam int EOF_BLOCK_BYTES = 28;
	localparam int CFG_DATA_BITS   = 64;
	localparam int CFG_ADDR_BITS   = 4;
	localparam int TDATA_BITS      = 72;

	localparam logic [LEN_BITS-1:0] MAX_BLOCK_BYTES = 17'd65536;
	localparam logic [LEN_BITS-1:0] MIN_LEN  = LEN_BITS'(HDR_BYTES + FOOTER_BYTES);
	localparam logic [LEN_BITS-1:0] EOF_LEN  = LEN_BITS'(EOF_BLOCK_BYTES);
	localparam logic [LEN_BITS-1:0] POS_SIZE_LO = 17'd16;
	localparam logic [LEN_BITS-1:0] POS_SIZE_HI = 17'd17;

	// Bit positions of the result fields inside m_tdata.
	localparam int ST_LSB  = 0;
	localparam int OFS_LSB = 2;
	localparam int LEN_LSB = OFS_LSB + OUT_OFS_BITS;

	typedef enum logic [1:0] {
		ST_BLOCK = 2'd0,
		ST_EOF   = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	typedef struct packed {
		status_t                  status;
		logic [OUT_OFS_BITS-1:0]  block_offset;
		logic [LEN_BITS-1:0]      block_length;
		logic                     final_res;
	} result_t;

	// Expected byte of the standard end-of-file block.
	function automatic logic [7:0] eof_byte(input logic [4:0] pos);
		logic [7:0] b;
		unique case (pos)
			5'd0:    b = 8'h1f;
			5'd1:    b = 8'h8b;
			5'd2:    b = 8'h08;
			5'd3:    b = 8'h04;
			5'd9:    b = 8'hff;
			5'd10:   b = 8'h06;
			5'd12:   b = 8'h42;
			5'd13:   b = 8'h43;
			5'd14:   b = 8'h02;
			5'd16:   b = 8'h1b;
			5'd18:   b = 8'h03;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Fixed header bytes within the first sixteen positions.
	function automatic logic header_ok(input logic [3:0] pos, input logic [7:0] b);
		logic ok;
		unique case (pos)
			4'd0:    ok = (b == 8'h1f);
			4'd1:    ok = (b == 8'h8b);
			4'd2:    ok = (b == 8'h08);
			4'd3:    ok = (b == 8'h04);
			4'd10:   ok = (b == 8'h06);
			4'd12:   ok = (b == 8'h42);
			4'd13:   ok = (b == 8'h43);
			4'd14:   ok = (b == 8'h02);
			4'd15:   ok = (b == 8'h00);
			default: ok = 1'b1;
		endcase
		return ok;
	endfunction

endpackage

`default_nettype wire

>>> hdl/bgzf_scan_core.sv
// ============================================================================
// Block scanner core
// Holds the per-block scan state and works out the result of one byte.
// ============================================================================
`default_nettype none

module bgzf_scan_core import bgzf_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     item_en,
	input  wire logic [7:0]               data_byte,
	input  wire logic                     last_byte,
	input  wire logic [OUT_OFS_BITS-1:0]  start_offset,
	input  wire logic                     cfg_load,
	input  wire logic [OUT_OFS_BITS-1:0]  cfg_offset,
	output logic                          res_valid,
	output result_t                       res
);

	logic [LEN_BITS-1:0]     pos_q;
	logic [LEN_BITS-1:0]     len_q;
	logic [7:0]              size_lo_q;
	logic [OFFSET_BITS-1:0]  blk_ofs_q;
	logic                    eof_q;
	logic                    drain_q;

	logic [LEN_BITS-1:0]     pos_n;
	logic [LEN_BITS-1:0]     len_n;
	logic [7:0]              size_lo_n;
	logic [OFFSET_BITS-1:0]  blk_ofs_n;
	logic                    eof_n;
	logic                    drain_n;
	logic                    rearm;

	logic                    eof_upd;
	logic                    hdr_ok;
	logic [LEN_BITS-1:0]     len_dec;
	logic [LEN_BITS-1:0]     len_eff;
	logic                    at_hi;
	logic                    len_bad;
	logic                    done;

	assign at_hi   = (pos_q == POS_SIZE_HI);
	assign eof_upd = eof_q & ~((pos_q < EOF_LEN) && (data_byte != eof_byte(pos_q[4:0])));
	assign hdr_ok  = (pos_q >= POS_SIZE_LO) || header_ok(pos_q[3:0], data_byte);
	assign len_dec = {1'b0, data_byte, size_lo_q} + 17'd1;
	assign len_eff = at_hi ? len_dec : len_q;
	assign len_bad = at_hi && ((len_dec < MIN_LEN) || (len_dec > MAX_BLOCK_BYTES));
	assign done    = (pos_q >= POS_SIZE_HI) && ((pos_q + 17'd1) == len_eff);

	always_comb begin
		pos_n              = pos_q + 17'd1;
		len_n              = len_eff;
		size_lo_n          = (pos_q == POS_SIZE_LO) ? data_byte : size_lo_q;
		blk_ofs_n          = blk_ofs_q;
		eof_n              = eof_upd;
		drain_n            = drain_q;
		rearm              = 1'b0;
		res_valid          = 1'b0;
		res.status         = ST_ERROR;
		res.block_offset   = blk_ofs_q[OUT_OFS_BITS-1:0];
		res.block_length   = '0;
		res.final_res      = 1'b1;

		if (drain_q) begin
			rearm = last_byte;
		end else if (!hdr_ok || len_bad) begin
			// Final error: re-arm on the last byte, otherwise drop bytes until it.
			res_valid        = 1'b1;
			res.block_length = hdr_ok ? len_dec : '0;
			rearm            = last_byte;
			drain_n          = ~last_byte;
		end else if (done) begin
			res_valid        = 1'b1;
			res.block_length = len_eff;
			if ((len_eff == EOF_LEN) && eof_upd) begin
				res.status = ST_EOF;
				rearm      = last_byte;
				drain_n    = ~last_byte;
			end else begin
				res.status    = ST_BLOCK;
				res.final_res = last_byte;
				rearm         = last_byte;
				pos_n         = '0;
				len_n         = '0;
				size_lo_n     = '0;
				eof_n         = 1'b1;
				blk_ofs_n     = blk_ofs_q + OFFSET_BITS'(len_eff);
			end
		end else if (last_byte) begin
			res_valid        = 1'b1;
			res.block_length = (pos_q >= POS_SIZE_HI) ? len_eff : '0;
			rearm            = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			len_q     <= '0;
			size_lo_q <= '0;
			blk_ofs_q <= '0;
			eof_q     <= 1'b1;
			drain_q   <= 1'b0;
		end else if (cfg_load || (item_en && rearm)) begin
			pos_q     <= '0;
			len_q     <= '0;
			size_lo_q <= '0;
			blk_ofs_q <= cfg_load ? OFFSET_BITS'(cfg_offset) : OFFSET_BITS'(start_offset);
			eof_q     <= 1'b1;
			drain_q   <= 1'b0;
		end else if (item_en) begin
			pos_q     <= pos_n;
			len_q     <= len_n;
			size_lo_q <= size_lo_n;
			blk_ofs_q <= blk_ofs_n;
			eof_q     <= eof_n;
			drain_q   <= drain_n;
		end
	end

endmodule

`default_nettype wire

>>> hdl/bgzf_block_scanner.sv
// Path: an accepted item is held in the input register, and its result then passes
// through the result register (or the skid entry) to m_tvalid.
// Throughput: one byte per cycle while the skid entry is free; state advances once per byte.
// A two-entry result buffer keeps input flowing while a result waits to be taken.
// Reset: arst_n asynchronously clears start_offset and control state, but sets the eof flag.
// ============================================================================
// Block scanner top level
// Finds compressed block boundaries in a byte stream and reports each block, end-of-file block and error.
// ============================================================================
`default_nettype none

module bgzf_block_scanner import bgzf_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [7:0]                s_tdata,   // [7:0] data_byte
	input  wire logic                      s_tlast,   // last_byte
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [TDATA_BITS-1:0]          m_tdata,   // [1:0] status, [49:2] block_offset,
	                                                  // [66:50] block_length, rest zero
	output logic                           m_tlast,   // final_res
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [CFG_ADDR_BITS-1:0]  paddr,
	input  wire logic [CFG_DATA_BITS-1:0]  pwdata,
	output logic [CFG_DATA_BITS-1:0]       prdata,
	output logic                           pready
);

	logic [OUT_OFS_BITS-1:0]  start_q;
	logic                     cfg_wr;

	logic                     vld_s1;
	logic [7:0]               byte_s1;
	logic                     last_s1;
	logic                     adv;

	logic                     res_valid;
	result_t                  res;

	logic                     m_valid_q;
	result_t                  m_res_q;
	logic                     sk_valid_q;
	result_t                  sk_res_q;
	logic                     pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[CFG_ADDR_BITS-1] == 1'b0);
	assign prdata = (paddr[CFG_ADDR_BITS-1] == 1'b0)
		? {{(CFG_DATA_BITS-OUT_OFS_BITS){1'b0}}, start_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_wr) begin
			start_q <= pwdata[OUT_OFS_BITS-1:0];
		end
	end

	// The input stage moves on whenever the skid entry is free.
	assign adv      = vld_s1 && !sk_valid_q;
	assign s_tready = !vld_s1 || !sk_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	bgzf_scan_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_en      (adv),
		.data_byte    (byte_s1),
		.last_byte    (last_s1),
		.start_offset (start_q),
		.cfg_load     (cfg_wr),
		.cfg_offset   (pwdata[OUT_OFS_BITS-1:0]),
		.res_valid    (res_valid),
		.res          (res)
	);

	assign pop = m_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q  <= 1'b0;
			sk_valid_q <= 1'b0;
		end else if (sk_valid_q) begin
			if (pop) begin
				m_valid_q  <= 1'b1;
				sk_valid_q <= 1'b0;
			end
		end else if (adv && res_valid) begin
			if (!m_valid_q || pop) begin
				m_valid_q <= 1'b1;
			end else begin
				sk_valid_q <= 1'b1;
			end
		end else if (pop) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_valid_q) begin
			if (pop) begin
				m_res_q <= sk_res_q;
			end
		end else if (adv && res_valid) begin
			if (!m_valid_q || pop) begin
				m_res_q <= res;
			end else begin
				sk_res_q <= res;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_res_q.final_res;
	assign m_tdata  = {{(TDATA_BITS-LEN_LSB-LEN_BITS){1'b0}}, m_res_q.block_length,
		m_res_q.block_offset, m_res_q.status};

endmodule

`default_nettype wire

>>> hdl/bgzf_chk.sv
// ============================================================================
// Block scanner port checker
// Watches the result channel of the scanner and is bound to its top level.
// ============================================================================
`default_nettype none

`include "bgzf_block_scanner_macros.svh"

module bgzf_chk import bgzf_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      m_tvalid,
	input  wire logic                      m_tready,
	input  wire logic [TDATA_BITS-1:0]     m_tdata,
	input  wire logic                      m_tlast
);

	logic [1:0]          st;
	logic [LEN_BITS-1:0] len;

	assign st  = m_tdata[ST_LSB +: 2];
	assign len = m_tdata[LEN_LSB +: LEN_BITS];

	`BGZF_ASSERT_NEXT(a_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

	`BGZF_ASSERT_SAME(a_eof_len, m_tvalid && (st == ST_EOF),
		(len == EOF_LEN) && m_tlast, "end-of-file result without length 28 and final mark")

	`BGZF_ASSERT_SAME(a_err_final, m_tvalid && (st == ST_ERROR),
		m_tlast, "error result not marked final")

	`BGZF_ASSERT_SAME(a_blk_len, m_tvalid && (st == ST_BLOCK),
		(len >= MIN_LEN) && (len <= MAX_BLOCK_BYTES), "block length out of range")

endmodule

bind bgzf_block_scanner bgzf_chk u_chk (.*);

`default_nettype wire

>>> bench/bgzf_scan_checker.sv
// ============================================================================
// Block scanner checker
// Watches the byte stream, the result stream and register writes, keeps its
// own copy of the scan state, and compares every result taken from the
// scanner with the oldest report it has worked out.
// ============================================================================
`timescale 1ns / 100ps

module bgzf_scan_checker import bgzf_pkg::*; #(
	parameter logic [CFG_ADDR_BITS-1:0] CFG_ADDR = '0
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	input  wire logic                      s_tready,
	input  wire logic [7:0]                s_tdata,   // [7:0] data_byte
	input  wire logic                      s_tlast,   // last_byte
	input  wire logic                      m_tvalid,
	input  wire logic                      m_tready,
	input  wire logic [TDATA_BITS-1:0]     m_tdata,   // [1:0] status, [49:2] block_offset,
	                                                  // [66:50] block_length, rest zero
	input  wire logic                      m_tlast,   // final_res
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [CFG_ADDR_BITS-1:0]  paddr,
	input  wire logic [CFG_DATA_BITS-1:0]  pwdata,
	input  wire logic                      pready,
	output int                             pending,
	output int                             fail_count
);

	// The standard end-of-file block, byte 0 first.
	localparam logic [0:EOF_BLOCK_BYTES-1][7:0] EOF_IMAGE = {
		8'h1f, 8'h8b, 8'h08, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'hff, 8'h06, 8'h00, 8'h42, 8'h43, 8'h02, 8'h00,
		8'h1b, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00
	};

	logic [OUT_OFS_BITS-1:0] origin;
	logic [LEN_BITS-1:0]     pos;
	logic [LEN_BITS-1:0]     blk_len;
	logic [7:0]              size_lo;
	logic [OFFSET_BITS-1:0]  blk_ofs;
	logic                    eof_match;
	logic                    draining;

	result_t reports_due[$];
	result_t want;
	result_t got;
	int      fails;

	function automatic void rearm();
		pos       = '0;
		blk_len   = '0;
		size_lo   = '0;
		blk_ofs   = OFFSET_BITS'(origin);
		eof_match = 1'b1;
		draining  = 1'b0;
	endfunction

	function automatic logic fixed_byte_ok(input logic [LEN_BITS-1:0] at, input logic [7:0] b);
		case (at)
			0:       return b == 8'h1f;
			1:       return b == 8'h8b;
			2:       return b == 8'h08;
			3:       return b == 8'h04;
			10:      return b == 8'h06;
			12:      return b == 8'h42;
			13:      return b == 8'h43;
			14:      return b == 8'h02;
			15:      return b == 8'h00;
			default: return 1'b1;
		endcase
	endfunction

	// A result that ends the scan: re-arm at once on the last byte, otherwise
	// drop everything up to it.
	function automatic logic close_scan(input status_t st, input logic [LEN_BITS-1:0] len,
			input logic last, output result_t res);
		res.status       = st;
		res.block_offset = blk_ofs[OUT_OFS_BITS-1:0];
		res.block_length = len;
		res.final_res    = 1'b1;
		if (last) begin
			rearm();
		end else begin
			draining = 1'b1;
		end
		return 1'b1;
	endfunction

	function automatic logic scan_byte(input logic [7:0] b, input logic last, output result_t res);
		logic [LEN_BITS-1:0] at;
		at  = pos;
		res = '0;
		if (draining) begin
			if (last) begin
				rearm();
			end
			return 1'b0;
		end
		if (at < EOF_LEN && b != EOF_IMAGE[at[4:0]]) begin
			eof_match = 1'b0;
		end
		if (!fixed_byte_ok(at, b)) begin
			return close_scan(ST_ERROR, '0, last, res);
		end
		if (at == POS_SIZE_LO) begin
			size_lo = b;
		end
		if (at == POS_SIZE_HI) begin
			blk_len = {b, size_lo} + 1'b1;
			if (blk_len < MIN_LEN || blk_len > MAX_BLOCK_BYTES) begin
				return close_scan(ST_ERROR, blk_len, last, res);
			end
		end
		if (at >= POS_SIZE_HI && at + 1'b1 == blk_len) begin
			if (blk_len == EOF_LEN && eof_match) begin
				return close_scan(ST_EOF, blk_len, last, res);
			end
			res.status       = ST_BLOCK;
			res.block_offset = blk_ofs[OUT_OFS_BITS-1:0];
			res.block_length = blk_len;
			res.final_res    = last;
			if (last) begin
				rearm();
			end else begin
				blk_ofs   = blk_ofs + OFFSET_BITS'(blk_len);
				pos       = '0;
				blk_len   = '0;
				size_lo   = '0;
				eof_match = 1'b1;
			end
			return 1'b1;
		end
		if (last) begin
			return close_scan(ST_ERROR, at >= POS_SIZE_HI ? blk_len : '0, 1'b1, res);
		end
		pos = at + 1'b1;
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin = '0;
			rearm();
			reports_due.delete();
			fails = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			// A write of the start offset also restarts the scan.
			if (psel && penable && pwrite && pready && paddr == CFG_ADDR) begin
				origin = pwdata[OUT_OFS_BITS-1:0];
				rearm();
			end
			if (s_tvalid && s_tready) begin
				if (scan_byte(s_tdata, s_tlast, want)) begin
					reports_due.insert(reports_due.size(), want);
				end
			end
			if (m_tvalid && m_tready) begin
				got.status       = status_t'(m_tdata[ST_LSB +: 2]);
				got.block_offset = m_tdata[OFS_LSB +: OUT_OFS_BITS];
				got.block_length = m_tdata[LEN_LSB +: LEN_BITS];
				got.final_res    = m_tlast;
				if (reports_due.size() == 0) begin
					fails++;
					$display("%0t: expected no result, got status %0d offset %h length %0d final %b",
						$time, got.status, got.block_offset, got.block_length, got.final_res);
				end else begin
					want = reports_due.pop_front();
					if (got !== want) begin
						fails++;
						$display("%0t: expected status %0d offset %h length %0d final %b",
							$time, want.status, want.block_offset, want.block_length,
							want.final_res);
						$display("%0t:      got status %0d offset %h length %0d final %b",
							$time, got.status, got.block_offset, got.block_length,
							got.final_res);
					end
				end
			end
			pending <= reports_due.size();
			fail_count <= fails;
		end
	end

endmodule

>>> bench/tb_bgzf_block_scanner.sv
// ============================================================================
// Block scanner testbench
// Feeds directed and random compressed streams into the scanner with random
// gaps and stalls, moves the start offset between phases, and leaves the
// checking to the checker beside the scanner.
// ============================================================================
`timescale 1ns / 100ps

module tb_bgzf_block_scanner;
	import bgzf_pkg::*;

	localparam logic [CFG_ADDR_BITS-1:0] CFG_START_OFFSET = '0;
	localparam int RESET_CYCLES = 3;
	localparam int IDLE_PCT     = 30;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 800;
	localparam int CYCLE_LIMIT  = 2000000;

	// Positions of the fixed header bytes, lowest entry first.
	localparam logic [8:0][3:0] FIXED_POS = {
		4'd15, 4'd14, 4'd13, 4'd12, 4'd10, 4'd3, 4'd2, 4'd1, 4'd0
	};

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [7:0]               s_tdata;
	logic                     s_tlast;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [TDATA_BITS-1:0]    m_tdata;
	logic                     m_tlast;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CFG_ADDR_BITS-1:0] paddr;
	logic [CFG_DATA_BITS-1:0] pwdata;
	logic [CFG_DATA_BITS-1:0] cfg_rdata;
	logic                     pready;
	int                       pending;
	int                       fail_count;
	int                       cycle_count = 0;
	int                       scan_bytes = 0;
	logic                     calm = 1'b0;
	logic [7:0]               stream_q[$];

	bgzf_block_scanner i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (cfg_rdata),
		.pready   (pready)
	);

	bgzf_scan_checker #(
		.CFG_ADDR (CFG_START_OFFSET)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		m_tready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic void put_byte(input logic [7:0] b);
		stream_q.insert(stream_q.size(), b);
	endfunction

	function automatic void add_random(input int n);
		repeat (n) put_byte(8'($urandom_range(0, 255)));
	endfunction

	function automatic void add_header(input logic [15:0] size);
		put_byte(8'h1f);
		put_byte(8'h8b);
		put_byte(8'h08);
		put_byte(8'h04);
		add_random(6);
		put_byte(8'h06);
		add_random(1);
		put_byte(8'h42);
		put_byte(8'h43);
		put_byte(8'h02);
		put_byte(8'h00);
		put_byte(size[7:0]);
		put_byte(size[15:8]);
	endfunction

	function automatic void add_block(input int len);
		add_header(16'(len - 1));
		add_random(len - HDR_BYTES);
	endfunction

	function automatic void add_eof();
		for (int i = 0; i < EOF_BLOCK_BYTES; i++) begin
			put_byte(eof_byte(5'(i)));
		end
	endfunction

	function automatic void corrupt(input int at, input logic [7:0] flip);
		stream_q[at] = stream_q[at] ^ flip;
	endfunction

	function automatic void trim(input int keep);
		while (stream_q.size() > keep) void'(stream_q.pop_back());
	endfunction

	// Mostly short blocks, now and then a longer one.
	function automatic int pick_len();
		if ($urandom_range(0, 99) < 3) begin
			return $urandom_range(200, 600);
		end
		return $urandom_range(MIN_LEN, 70);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_stream(input logic mark_last);
		for (int i = 0; i < stream_q.size(); i++) begin
			send_byte(stream_q[i], mark_last && i == stream_q.size() - 1);
		end
		stream_q.delete();
	endtask

	// Hold the stream until every report is in and the pipeline has emptied.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [OUT_OFS_BITS-1:0] value);
		logic [15:0] junk;
		junk = 16'($urandom);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_START_OFFSET;
		pwdata  <= {junk, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// One stream, always closed by a last-marked byte. Bytes that the scanner
	// drops after an error or an end-of-file block are left out of the count.
	task automatic random_stream();
		int kind;
		int start;
		int p;
		int tail;
		kind = $urandom_range(0, 99);
		tail = 0;
		repeat ($urandom_range(0, 3)) add_block(pick_len());
		start = stream_q.size();
		if (kind < 55) begin
			add_block(pick_len());
			if ($urandom_range(0, 2) == 0) begin
				add_eof();
			end
		end else if (kind < 65) begin
			add_block(pick_len());
			trim($urandom_range(start + 1, stream_q.size() - 1));
		end else if (kind < 75) begin
			add_header(16'($urandom_range(25, 200)));
			add_random(4);
			p = FIXED_POS[$urandom_range(0, 8)];
			corrupt(start + p, 8'($urandom_range(1, 255)));
			tail = $urandom_range(0, 4);
			trim(start + p + 1 + tail);
		end else if (kind < 83) begin
			add_header(16'($urandom_range(0, 24)));
			tail = $urandom_range(0, 4);
			add_random(tail);
		end else if (kind < 90) begin
			add_eof();
			tail = $urandom_range(1, 4);
			add_random(tail);
		end else if (kind < 95) begin
			// Almost the end-of-file block: reported as an ordinary block.
			add_eof();
			p = $urandom_range(0, 1) ? $urandom_range(4, 9) : $urandom_range(18, 27);
			corrupt(start + p, 8'($urandom_range(1, 255)));
			add_block(pick_len());
		end else begin
			add_random($urandom_range(1, 8));
		end
		scan_bytes += stream_q.size() - tail;
		send_stream(1'b1);
	endtask

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_write('0);
		add_block(MIN_LEN);
		add_block(27);
		add_eof();
		send_stream(1'b1);
		add_block(300);
		send_stream(1'b1);
		add_eof();
		add_random(3);
		send_stream(1'b1);
		add_eof();
		corrupt(20, 8'h01);
		add_block(MIN_LEN);
		send_stream(1'b1);
		// Each fixed header byte wrong in turn, some with the last mark on it.
		for (int k = 0; k < 9; k++) begin
			add_header(16'd40);
			corrupt(FIXED_POS[k], 8'hff);
			trim(FIXED_POS[k] + 1 + (k % 2) * 2);
			send_stream(1'b1);
		end
		add_header(16'd0);
		add_random(2);
		send_stream(1'b1);
		add_header(16'd24);
		send_stream(1'b1);
		put_byte(8'h1f);
		send_stream(1'b1);
		add_block(40);
		trim(17);
		send_stream(1'b1);
		add_block(40);
		trim(18);
		send_stream(1'b1);
		add_block(40);
		trim(39);
		send_stream(1'b1);

		settle();
		apb_write('1);
		add_block(MIN_LEN);
		add_block(30);
		add_eof();
		send_stream(1'b1);

		// The largest size field is accepted and then cut short by the last mark.
		settle();
		apb_write(48'({$urandom, $urandom}));
		add_header(16'hffff);
		add_random(6);
		send_stream(1'b1);

		// A write in the middle of a block restarts the scan.
		add_block(40);
		trim(10);
		send_stream(1'b0);
		settle();
		apb_write(48'({$urandom, $urandom}));
		add_block(MIN_LEN);
		send_stream(1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			settle();
			case (ph)
				0:       apb_write(48'({$urandom, $urandom}));
				1:       apb_write(48'hffff_ffff_ffff - $urandom_range(0, 4000));
				2:       apb_write('0);
				default: apb_write(48'({$urandom, $urandom}));
			endcase
			calm = (ph == 2);
			while (scan_bytes < RANDOM_ITEMS * (ph + 1) / 4) random_stream();
		end

		settle();
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
